// File: design/kva_pkg.sv
// Shared widths, register indexes, constants and interface types of the knob accumulator
package kva_pkg;

  localparam int DELTA_W    = 8;
  localparam int TIME_W     = 32;
  localparam int VALUE_W    = 16;
  localparam int SPEED_W    = 16;
  localparam int DIVIDEND_W = 16;
  localparam int MULT_W     = 5;
  localparam int SCALED_W   = DELTA_W + MULT_W - 1;
  localparam int SUM_W      = VALUE_W + 2;
  localparam int CNT_W      = $clog2(DIVIDEND_W + 1);
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT = 1'd1;

  localparam logic signed [VALUE_W-1:0] MIN_LIMIT_RST = 16'sd0;
  localparam logic signed [VALUE_W-1:0] MAX_LIMIT_RST = 16'sd1024;

  localparam logic [DIVIDEND_W-1:0] SPEED_SCALE = 16'd500;
  localparam logic [SPEED_W-1:0]    SPEED_SAT   = 16'hFFFF;
  localparam logic [SPEED_W-1:0]    SPEED_FIRST = 16'd1;

  localparam logic [SPEED_W:0] SUM_FAST = 17'd3;
  localparam logic [SPEED_W:0] SUM_MID  = 17'd2;
  localparam logic [SPEED_W:0] SUM_SLOW = 17'd1;

  localparam logic signed [MULT_W-1:0] MULT_FAST = 5'sd10;
  localparam logic signed [MULT_W-1:0] MULT_MID  = 5'sd5;
  localparam logic signed [MULT_W-1:0] MULT_SLOW = 5'sd3;
  localparam logic signed [MULT_W-1:0] MULT_NONE = 5'sd1;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [TIME_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: design/knob_velocity_accumulator.sv
// Knob velocity accumulator: top level with control, state and output register
//
// Usage:
//   cfg_we/cfg_index/cfg_wdata write min_limit (index 0) and max_limit
//   (index 1); write them only while the block is idle.
//   Input items (opcode, count_delta, time_ms, new_value) are taken on
//   in_valid && in_ready; results (changed, knob_value) leave on
//   out_valid && out_ready.
//   A set item passes through S_FIN into the output register. An update
//   item that needs a speed division first waits in S_DIV for the 16-step
//   bit-serial divider, one quotient bit per cycle, then passes through
//   S_FIN. Other updates go straight to S_FIN, and an idle
//   update (zero delta, no set pending) is dropped in the cycle it is taken.
//   One item is worked on at a time; the next item is taken while a result
//   waits in the output register, and work stalls before the state update
//   until that register is free.
//   Reset clears the knob value, timestamp, speed (to 1), the pending flag,
//   the limits (to 0 and 1024) and out_valid.
module knob_velocity_accumulator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [kva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kva_pkg::VALUE_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic signed [kva_pkg::DELTA_W-1:0] count_delta,
  input  logic [kva_pkg::TIME_W-1:0]         time_ms,
  input  logic signed [kva_pkg::VALUE_W-1:0] new_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               changed,
  output logic signed [kva_pkg::VALUE_W-1:0] knob_value
);
  import kva_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                state;
  logic                      op_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [TIME_W-1:0]         time_q;
  logic signed [VALUE_W-1:0] nv_q;
  logic [SPEED_W-1:0]        speed_q;

  logic signed [VALUE_W-1:0] min_limit;
  logic signed [VALUE_W-1:0] max_limit;
  logic [TIME_W-1:0]         last_time;
  logic [SPEED_W-1:0]        last_speed;
  logic signed [VALUE_W-1:0] knob_accum;
  logic                      manual_pending;

  logic                      accept;
  logic                      idle_upd;
  logic                      need_div;
  logic                      fin;
  logic [DELTA_W-1:0]        mag;
  logic [TIME_W-1:0]         elapsed;
  logic signed [VALUE_W-1:0] upd_value;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idle_upd = !opcode && (count_delta == '0) && !manual_pending;
  assign elapsed  = time_ms - last_time;
  assign need_div = !opcode && !idle_upd && (last_time != '0) && (elapsed != '0);
  assign mag      = count_delta[DELTA_W-1] ? DELTA_W'(-count_delta) : DELTA_W'(count_delta);
  assign fin      = (state == S_FIN) && (!out_valid || out_ready);

  assign div_req.start    = accept && need_div;
  assign div_req.dividend = DIVIDEND_W'({{(DIVIDEND_W-DELTA_W){1'b0}}, mag} * SPEED_SCALE);
  assign div_req.divisor  = elapsed;

  kva_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  kva_update u_update (
    .speed      (speed_q),
    .last_speed (last_speed),
    .delta      (delta_q),
    .accum      (knob_accum),
    .min_limit  (min_limit),
    .max_limit  (max_limit),
    .value      (upd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_limit <= MIN_LIMIT_RST;
      max_limit <= MAX_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LIMIT: min_limit <= cfg_wdata;
        REG_MAX_LIMIT: max_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && !idle_upd) begin
            state <= need_div ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode;
      delta_q <= count_delta;
      time_q  <= time_ms;
      nv_q    <= new_value;
      speed_q <= (last_time == '0) ? SPEED_FIRST : SPEED_SAT;
    end else if (state == S_DIV && div_rsp.done) begin
      speed_q <= div_rsp.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time      <= '0;
      last_speed     <= SPEED_FIRST;
      knob_accum     <= '0;
      manual_pending <= 1'b0;
    end else if (fin) begin
      if (op_q) begin
        knob_accum     <= nv_q;
        manual_pending <= 1'b1;
      end else begin
        last_time      <= time_q;
        last_speed     <= speed_q;
        knob_accum     <= upd_value;
        manual_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      changed    <= !op_q;
      knob_value <= op_q ? nv_q : upd_value;
    end
  end

endmodule

// File: design/kva_div.sv
// Bit-serial restoring divider: one quotient bit per cycle
module kva_div (
  input  logic              clk,
  input  logic              rst,
  input  kva_pkg::div_req_t req,
  output kva_pkg::div_rsp_t rsp
);
  import kva_pkg::*;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] work;
  logic [DIVIDEND_W-1:0] rem;
  logic [TIME_W-1:0]     divisor;
  logic [DIVIDEND_W:0]   trial;
  logic [TIME_W-1:0]     trial_ext;
  logic [TIME_W-1:0]     diff;
  logic                  fits;

  assign trial     = {rem, work[DIVIDEND_W-1]};
  assign trial_ext = {{(TIME_W-DIVIDEND_W-1){1'b0}}, trial};
  assign fits      = trial_ext >= divisor;
  assign diff      = trial_ext - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work    <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy && cnt != '0) begin
      work <= {work[DIVIDEND_W-2:0], fits};
      rem  <= fits ? diff[DIVIDEND_W-1:0] : trial[DIVIDEND_W-1:0];
    end
  end

  assign rsp.done     = busy && (cnt == '0);
  assign rsp.quotient = work;

endmodule

// File: design/kva_update.sv
// Speed-dependent delta scaling, accumulation and clamping of the knob value
module kva_update (
  input  logic [kva_pkg::SPEED_W-1:0]        speed,
  input  logic [kva_pkg::SPEED_W-1:0]        last_speed,
  input  logic signed [kva_pkg::DELTA_W-1:0] delta,
  input  logic signed [kva_pkg::VALUE_W-1:0] accum,
  input  logic signed [kva_pkg::VALUE_W-1:0] min_limit,
  input  logic signed [kva_pkg::VALUE_W-1:0] max_limit,
  output logic signed [kva_pkg::VALUE_W-1:0] value
);
  import kva_pkg::*;

  logic [SPEED_W:0]             sum;
  logic signed [MULT_W-1:0]     mult;
  logic signed [SCALED_W-1:0]   scaled;
  logic signed [SUM_W-1:0]      raw;
  logic signed [SUM_W-1:0]      upper;
  logic signed [SUM_W-1:0]      clamped;

  assign sum = {1'b0, speed} + {1'b0, last_speed};

  always_comb begin
    if (sum >= SUM_FAST) begin
      mult = MULT_FAST;
    end else if (sum >= SUM_MID) begin
      mult = MULT_MID;
    end else if (sum >= SUM_SLOW) begin
      mult = MULT_SLOW;
    end else begin
      mult = MULT_NONE;
    end
  end

  assign scaled = SCALED_W'(delta) * SCALED_W'(mult);
  assign raw    = SUM_W'(accum) + SUM_W'(scaled);

  always_comb begin
    upper   = (raw > SUM_W'(max_limit)) ? SUM_W'(max_limit) : raw;
    clamped = (upper < SUM_W'(min_limit)) ? SUM_W'(min_limit) : upper;
  end

  assign value = clamped[VALUE_W-1:0];

endmodule

// File: design/kva_checker.sv
// Port-level checks of the knob accumulator and their binding to the top level
module kva_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_we,
  input logic [kva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [kva_pkg::VALUE_W-1:0]        cfg_wdata,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               opcode,
  input logic signed [kva_pkg::VALUE_W-1:0] new_value,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               changed,
  input logic signed [kva_pkg::VALUE_W-1:0] knob_value
);
  import kva_pkg::*;

  logic signed [VALUE_W-1:0] min_sh;
  logic signed [VALUE_W-1:0] max_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sh <= MIN_LIMIT_RST;
      max_sh <= MAX_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LIMIT: min_sh <= cfg_wdata;
        REG_MAX_LIMIT: max_sh <= cfg_wdata;
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(knob_value) && $stable(changed))
    else $error("result changed while stalled");

  a_set_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode |=> !in_ready)
    else $error("item taken while a set item is in work");

  a_set_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode && !out_valid |=>
      !out_valid ##1 (out_valid && !changed && knob_value == $past(new_value, 2)))
    else $error("set item result wrong or late");

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && changed && (min_sh <= max_sh) |->
      (knob_value >= min_sh) && (knob_value <= max_sh))
    else $error("update result outside limits");

endmodule

bind knob_velocity_accumulator kva_checker u_kva_checker (.*);

// File: sim/knob_velocity_accumulator_tb.sv
// Testbench for the knob velocity accumulator: directed and random items checked against a predictor
module knob_velocity_accumulator_tb;
  import kva_pkg::*;

  localparam logic OP_UPDATE     = 1'b0;
  localparam logic OP_SET        = 1'b1;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   RANDOM_ITEMS  = 1750;
  localparam int   PHASE_ITEMS   = 250;

  typedef struct packed {
    logic                      changed;
    logic signed [VALUE_W-1:0] knob_value;
  } knob_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_MIN_LIMIT;
  logic [VALUE_W-1:0]        cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      opcode = OP_UPDATE;
  logic signed [DELTA_W-1:0] count_delta = '0;
  logic [TIME_W-1:0]         time_ms = '0;
  logic signed [VALUE_W-1:0] new_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      changed;
  logic signed [VALUE_W-1:0] knob_value;

  // predictor state
  logic signed [VALUE_W-1:0] lim_lo;
  logic signed [VALUE_W-1:0] lim_hi;
  logic signed [VALUE_W-1:0] knob_now;
  logic [TIME_W-1:0]         stamp_prev;
  logic [SPEED_W-1:0]        speed_prev;
  logic                      set_pending;

  knob_result_t      knob_due_q[$];
  int                fail_count = 0;
  bit                steady = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;

  knob_velocity_accumulator u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .count_delta(count_delta),
    .time_ms    (time_ms),
    .new_value  (new_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .changed    (changed),
    .knob_value (knob_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic bit predict_knob(input logic op, input logic signed [DELTA_W-1:0] delta,
                                      input logic [TIME_W-1:0] now,
                                      input logic signed [VALUE_W-1:0] nv,
                                      output knob_result_t res);
    logic [31:0]        mag;
    logic [TIME_W-1:0]  elapsed;
    logic [31:0]        quot;
    logic [SPEED_W-1:0] speed;
    logic [SPEED_W:0]   sum;
    int                 gain;
    int                 acc;
    res = '0;
    if (op == OP_SET) begin
      knob_now       = nv;
      set_pending    = 1'b1;
      res.changed    = 1'b0;
      res.knob_value = nv;
      return 1'b1;
    end
    if (delta == 0 && !set_pending) return 1'b0;
    acc = delta;
    mag = (acc < 0) ? -acc : acc;
    if (stamp_prev == '0) begin
      speed = SPEED_FIRST;
    end else begin
      elapsed = now - stamp_prev;
      if (elapsed == '0) begin
        speed = SPEED_SAT;
      end else begin
        quot  = (mag * 32'd500) / elapsed;
        speed = (quot > 32'(SPEED_SAT)) ? SPEED_SAT : quot[SPEED_W-1:0];
      end
    end
    stamp_prev = now;
    sum = {1'b0, speed} + {1'b0, speed_prev};
    if (sum >= SUM_FAST) gain = int'(MULT_FAST);
    else if (sum >= SUM_MID) gain = int'(MULT_MID);
    else if (sum >= SUM_SLOW) gain = int'(MULT_SLOW);
    else gain = int'(MULT_NONE);
    speed_prev = speed;
    acc = int'(knob_now) + int'(delta) * gain;
    if (acc > lim_hi) acc = lim_hi;
    if (acc < lim_lo) acc = lim_lo;
    knob_now       = VALUE_W'(acc);
    set_pending    = 1'b0;
    res.changed    = 1'b1;
    res.knob_value = knob_now;
    return 1'b1;
  endfunction

  task automatic send_item(input logic op, input logic signed [DELTA_W-1:0] delta,
                           input logic [TIME_W-1:0] now, input logic signed [VALUE_W-1:0] nv);
    int           gap;
    knob_result_t res;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    count_delta <= delta;
    time_ms     <= now;
    new_value   <= nv;
    do @(posedge clk); while (!in_ready);
    if (predict_knob(op, delta, now, nv, res)) knob_due_q.push_back(res);
  endtask

  task automatic update_knob(input logic signed [DELTA_W-1:0] delta,
                             input logic [TIME_W-1:0] now);
    send_item(OP_UPDATE, delta, now, VALUE_W'($urandom));
  endtask

  task automatic set_knob(input logic signed [VALUE_W-1:0] nv);
    send_item(OP_SET, DELTA_W'($urandom), TIME_W'($urandom), nv);
  endtask

  // drain every result, then let the block sit idle with in_valid low
  task automatic settle();
    in_valid <= 1'b0;
    while (knob_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic signed [VALUE_W-1:0] lo,
                            input logic signed [VALUE_W-1:0] hi);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_LIMIT;
    cfg_wdata <= lo;
    @(posedge clk);
    lim_lo = lo;
    cfg_index <= REG_MAX_LIMIT;
    cfg_wdata <= hi;
    @(posedge clk);
    lim_hi = hi;
    cfg_we <= 1'b0;
  endtask

  task automatic test_speed_bands();
    update_knob(8'sd5, 32'd1000);
    update_knob(8'sd0, 32'd2000);
    update_knob(8'sd127, 32'd1000);
    update_knob(-8'sd128, 32'd1001);
    set_knob(16'sd500);
    update_knob(-8'sd1, 32'd101001);
    update_knob(-8'sd1, 32'd201001);
    update_knob(8'sd1, 32'd201501);
    update_knob(8'sd1, 32'd202001);
  endtask

  task automatic test_set_pending();
    set_knob(16'sd32767);
    update_knob(8'sd0, 32'd300000);
    set_knob(-16'sd32768);
    update_knob(8'sd0, 32'd300001);
  endtask

  task automatic test_timestamps();
    update_knob(8'sd3, 32'd0);
    update_knob(8'sd3, 32'd50);
    update_knob(8'sd2, 32'd10);
    update_knob(8'sd2, 32'hFFFF_FFFF);
    update_knob(8'sd2, 32'd5);
    send_item(OP_SET, -8'sd128, 32'hFFFF_FFFF, 16'sd0);
  endtask

  task automatic test_limit_extremes();
    set_limits(-16'sd32768, 16'sd32767);
    set_knob(16'sd32760);
    update_knob(8'sd127, 32'd6);
    set_knob(-16'sd32760);
    update_knob(-8'sd128, 32'd6);
  endtask

  task automatic test_crossed_limits();
    set_limits(16'sd100, -16'sd100);
    update_knob(8'sd1, 32'd900);
    set_knob(16'sd7);
    update_knob(-8'sd1, 32'd1900);
  endtask

  task automatic test_random_traffic();
    int                        n;
    int                        pick;
    int                        mag;
    logic signed [DELTA_W-1:0] delta;
    logic [TIME_W-1:0]         now;
    logic signed [VALUE_W-1:0] lo;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % PHASE_ITEMS == 0) begin
        case ((n / PHASE_ITEMS) % 5)
          0: begin
            lo = VALUE_W'($urandom_range(0, 2000) - 1000);
            set_limits(lo, lo + VALUE_W'($urandom_range(0, 3000)));
          end
          1: set_limits(-16'sd32768, 16'sd32767);
          2: set_limits(MIN_LIMIT_RST, MAX_LIMIT_RST);
          3: set_limits(VALUE_W'($urandom), VALUE_W'($urandom));
          default: begin
            lo = VALUE_W'($urandom);
            set_limits(lo, lo);
          end
        endcase
      end
      if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        n++;
        if (pick < 5) set_knob(VALUE_W'($urandom));
        else set_knob(lim_hi + VALUE_W'($urandom_range(0, 8)) - 16'sd4);
      end else begin
        case ($urandom_range(0, 9))
          0: delta = '0;
          1: begin
            case ($urandom_range(0, 3))
              0: delta = -8'sd128;
              1: delta = 8'sd127;
              2: delta = 8'sd1;
              default: delta = -8'sd1;
            endcase
          end
          2, 3: delta = DELTA_W'($urandom_range(0, 6) - 3);
          default: delta = DELTA_W'($urandom);
        endcase
        mag = delta;
        if (mag < 0) mag = -mag;
        case ($urandom_range(0, 19))
          0: now = clock_ms;
          1: now = '0;
          2: now = $urandom;
          3: now = clock_ms + $urandom_range(64001, 1 << 20);
          4, 5, 6, 7: now = clock_ms + $urandom_range(1, 16);
          8, 9, 10: now = clock_ms + (mag * 500) / $urandom_range(1, 3) + $urandom_range(0, 2);
          default: now = clock_ms + $urandom_range(1, 1000 * (mag + 1));
        endcase
        clock_ms = now;
        n++;
        update_knob(delta, now);
      end
    end
    steady = 1'b0;
  endtask

  // result side: before each result, hold out_ready low for a random wait, none while steady
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall - 1) @(posedge clk);
        out_ready <= 1'b1;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    knob_result_t due;
    if (!rst && out_valid && out_ready) begin
      if (knob_due_q.size() == 0) begin
        $error("knob_value: no item expected, got %0d", knob_value);
        fail_count++;
      end else begin
        due = knob_due_q.pop_front();
        if (changed !== due.changed) begin
          $error("changed: expected %0d, got %0d", due.changed, changed);
          fail_count++;
        end
        if (knob_value !== due.knob_value) begin
          $error("knob_value: expected %0d, got %0d", due.knob_value, knob_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    lim_lo      = MIN_LIMIT_RST;
    lim_hi      = MAX_LIMIT_RST;
    knob_now    = '0;
    stamp_prev  = '0;
    speed_prev  = SPEED_FIRST;
    set_pending = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_speed_bands();
    test_set_pending();
    test_timestamps();
    test_limit_extremes();
    test_crossed_limits();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
design/kva_pkg.sv
design/kva_div.sv
design/kva_update.sv
design/knob_velocity_accumulator.sv
design/kva_checker.sv
sim/knob_velocity_accumulator_tb.sv
